>>> hdl/b2d_pkg.sv
// ---------------------------------------------------------------------------
// b2d_pkg
// Shared types and constants of the 2-D viscous Burgers stencil engine.
// ---------------------------------------------------------------------------
`default_nettype none

package b2d_pkg;

   // field and register widths
   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 32;
   localparam int LEN_W       = 9;
   localparam int ROWS_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // register stages in one arithmetic lane, output register included
   localparam int LANE_DEPTH = 6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_TOTAL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIFFUSION_X = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIFFUSION_Y = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADVECTION_X = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADVECTION_Y = 3'd5;

   // register reset values
   localparam logic [LEN_W-1:0]  ROW_LENGTH_RST = 9'd256;
   localparam logic [ROWS_W-1:0] ROW_TOTAL_RST  = 16'd256;
   localparam logic [COEF_W-1:0] DIFFUSION_RST  = 32'd429496730;
   localparam logic [COEF_W-1:0] ADVECTION_RST  = 32'd107374182;

   // smallest legal row length and row count
   localparam logic [LEN_W-1:0]  LEN_MIN  = 9'd3;
   localparam logic [ROWS_W-1:0] ROWS_MIN = 16'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // saturation limits of a sample
   localparam sample_type SAT_MAX = 24'sh7FFFFF;
   localparam sample_type SAT_MIN = 24'sh800000;

   // one grid point, u in the low half
   typedef struct packed {
      sample_type v;
      sample_type u;
   } point_type;

   // one window column: row above, centre row, arriving row
   typedef struct packed {
      point_type top;
      point_type mid;
      point_type low;
   } column_type;

   // one line store word: both stored rows of one column
   typedef struct packed {
      point_type upper;
      point_type middle;
   } line_word_type;

   // stencil coefficients, unsigned Q0.32
   typedef struct packed {
      logic [COEF_W-1:0] diffusion_x;
      logic [COEF_W-1:0] diffusion_y;
      logic [COEF_W-1:0] advection_x;
      logic [COEF_W-1:0] advection_y;
   } coef_type;

endpackage

`default_nettype wire

>>> hdl/b2d_line_store.sv
// ---------------------------------------------------------------------------
// b2d_line_store
// Two stored grid rows in one memory, one word per column, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module b2d_line_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output b2d_pkg::line_word_type     rd_data,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  b2d_pkg::line_word_type     wr_data
);

   b2d_pkg::line_word_type mem_ff [DEPTH];
   b2d_pkg::line_word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/b2d_cell.sv
// ---------------------------------------------------------------------------
// b2d_cell
// One window column cell: holds a column of the 3x3 window and hands it on.
// ---------------------------------------------------------------------------
`default_nettype none

module b2d_cell (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           shift_en,
   input  b2d_pkg::column_type shift_column,
   output b2d_pkg::column_type held_column
);

   b2d_pkg::column_type column_ff;

   // column register, cleared to zero at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else if (shift_en) begin
         column_ff <= shift_column;
      end
   end

   assign held_column = column_ff;

endmodule

`default_nettype wire

>>> hdl/b2d_lane.sv
// ---------------------------------------------------------------------------
// b2d_lane
// Arithmetic lane for one velocity component: diffusion and advection terms,
// each rounded on its own, summed and saturated over six register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module b2d_lane #(
   parameter int FRAC_BITS = 20
) (
   input  wire logic          clock,
   input  wire logic          advance,
   input  b2d_pkg::sample_type centre,
   input  b2d_pkg::sample_type north,
   input  b2d_pkg::sample_type south,
   input  b2d_pkg::sample_type west,
   input  b2d_pkg::sample_type east,
   input  b2d_pkg::sample_type u_centre,
   input  b2d_pkg::sample_type v_centre,
   input  b2d_pkg::coef_type   coef,
   output b2d_pkg::sample_type result
);

   localparam int ADV_SHIFT = 2 * FRAC_BITS + 16;

   // stage 1: laplacians, central differences, magnitudes
   logic signed [25:0] lap_x, lap_y;
   logic signed [24:0] dif_x, dif_y;
   b2d_pkg::sample_type c1_ff;
   logic [25:0] lapx_mag_ff, lapy_mag_ff;
   logic        lapx_neg_ff, lapy_neg_ff;
   logic [23:0] uc_mag_ff, vc_mag_ff;
   logic [24:0] difx_mag_ff, dify_mag_ff;
   logic        advx_neg_ff, advy_neg_ff;

   assign lap_x = 26'(east) + 26'(west) - (26'(centre) <<< 1);
   assign lap_y = 26'(south) + 26'(north) - (26'(centre) <<< 1);
   assign dif_x = 25'(east) - 25'(west);
   assign dif_y = 25'(south) - 25'(north);

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff       <= centre;
         lapx_mag_ff <= lap_x[25] ? 26'(-lap_x) : 26'(lap_x);
         lapy_mag_ff <= lap_y[25] ? 26'(-lap_y) : 26'(lap_y);
         lapx_neg_ff <= lap_x[25];
         lapy_neg_ff <= lap_y[25];
         uc_mag_ff   <= u_centre[23] ? 24'(-u_centre) : 24'(u_centre);
         vc_mag_ff   <= v_centre[23] ? 24'(-v_centre) : 24'(v_centre);
         difx_mag_ff <= dif_x[24] ? 25'(-dif_x) : 25'(dif_x);
         dify_mag_ff <= dif_y[24] ? 25'(-dif_y) : 25'(dif_y);
         advx_neg_ff <= u_centre[23] ^ dif_x[24];
         advy_neg_ff <= v_centre[23] ^ dif_y[24];
      end
   end

   // stage 2: diffusion products and velocity times difference
   b2d_pkg::sample_type c2_ff;
   logic [57:0] diffx_prod_ff, diffy_prod_ff;
   logic [47:0] advx_mag_ff, advy_mag_ff;
   logic        lapx_neg2_ff, lapy_neg2_ff, advx_neg2_ff, advy_neg2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         c2_ff         <= c1_ff;
         diffx_prod_ff <= 58'(lapx_mag_ff) * 58'(coef.diffusion_x);
         diffy_prod_ff <= 58'(lapy_mag_ff) * 58'(coef.diffusion_y);
         advx_mag_ff   <= 48'(49'(uc_mag_ff) * 49'(difx_mag_ff));
         advy_mag_ff   <= 48'(49'(vc_mag_ff) * 49'(dify_mag_ff));
         lapx_neg2_ff  <= lapx_neg_ff;
         lapy_neg2_ff  <= lapy_neg_ff;
         advx_neg2_ff  <= advx_neg_ff;
         advy_neg2_ff  <= advy_neg_ff;
      end
   end

   // stage 3: diffusion rounding, advection coefficient partial products
   b2d_pkg::sample_type c3_ff;
   logic [25:0] diffx_mag_ff, diffy_mag_ff;
   logic [63:0] advx_hi_ff, advx_lo_ff, advy_hi_ff, advy_lo_ff;
   logic        lapx_neg3_ff, lapy_neg3_ff, advx_neg3_ff, advy_neg3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         c3_ff        <= c2_ff;
         diffx_mag_ff <= diffx_prod_ff[57:32] + 26'(diffx_prod_ff[31]);
         diffy_mag_ff <= diffy_prod_ff[57:32] + 26'(diffy_prod_ff[31]);
         advx_hi_ff   <= 64'(advx_mag_ff) * 64'(coef.advection_x[31:16]);
         advx_lo_ff   <= 64'(advx_mag_ff) * 64'(coef.advection_x[15:0]);
         advy_hi_ff   <= 64'(advy_mag_ff) * 64'(coef.advection_y[31:16]);
         advy_lo_ff   <= 64'(advy_mag_ff) * 64'(coef.advection_y[15:0]);
         lapx_neg3_ff <= lapx_neg2_ff;
         lapy_neg3_ff <= lapy_neg2_ff;
         advx_neg3_ff <= advx_neg2_ff;
         advy_neg3_ff <= advy_neg2_ff;
      end
   end

   // stage 4: signed diffusion terms, advection partial sum
   b2d_pkg::sample_type c4_ff;
   logic signed [26:0] diffx_term_ff, diffy_term_ff;
   logic [63:0] advx_sum_ff, advy_sum_ff;
   logic        advx_neg4_ff, advy_neg4_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         c4_ff         <= c3_ff;
         diffx_term_ff <= lapx_neg3_ff ? -$signed({1'b0, diffx_mag_ff})
                                       :  $signed({1'b0, diffx_mag_ff});
         diffy_term_ff <= lapy_neg3_ff ? -$signed({1'b0, diffy_mag_ff})
                                       :  $signed({1'b0, diffy_mag_ff});
         advx_sum_ff   <= advx_hi_ff + (advx_lo_ff >> 16);
         advy_sum_ff   <= advy_hi_ff + (advy_lo_ff >> 16);
         advx_neg4_ff  <= advx_neg3_ff;
         advy_neg4_ff  <= advy_neg3_ff;
      end
   end

   // stage 5: advection rounding, negated contribution
   logic [32:0] advx_round, advy_round;
   b2d_pkg::sample_type c5_ff;
   logic signed [26:0] diffx_term5_ff, diffy_term5_ff;
   logic signed [33:0] advx_part_ff, advy_part_ff;

   assign advx_round = 33'(advx_sum_ff >> ADV_SHIFT)
                     + 33'((advx_sum_ff >> (ADV_SHIFT - 1)) & 64'd1);
   assign advy_round = 33'(advy_sum_ff >> ADV_SHIFT)
                     + 33'((advy_sum_ff >> (ADV_SHIFT - 1)) & 64'd1);

   always_ff @(posedge clock) begin
      if (advance) begin
         c5_ff          <= c4_ff;
         diffx_term5_ff <= diffx_term_ff;
         diffy_term5_ff <= diffy_term_ff;
         advx_part_ff   <= advx_neg4_ff ?  $signed({1'b0, advx_round})
                                        : -$signed({1'b0, advx_round});
         advy_part_ff   <= advy_neg4_ff ?  $signed({1'b0, advy_round})
                                        : -$signed({1'b0, advy_round});
      end
   end

   // stage 6: sum of all terms and saturation
   logic signed [35:0] total;
   b2d_pkg::sample_type result_in, result_ff;

   assign total = 36'(c5_ff) + 36'(diffx_term5_ff) + 36'(diffy_term5_ff)
                + 36'(advx_part_ff) + 36'(advy_part_ff);

   always_comb begin
      if (total > 36'(b2d_pkg::SAT_MAX)) begin
         result_in = b2d_pkg::SAT_MAX;
      end else if (total < 36'(b2d_pkg::SAT_MIN)) begin
         result_in = b2d_pkg::SAT_MIN;
      end else begin
         result_in = total[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

>>> hdl/burgers_2d_explicit_stencil.sv
// ---------------------------------------------------------------------------
// burgers_2d_explicit_stencil
// Streaming explicit step of the 2-D viscous Burgers equations: raster grid
// points in, updated interior points out, via line store and window cells.
// ---------------------------------------------------------------------------
//  channel   ports            direction   moves
//  req       valid / stall    in          one grid point (u, v) per transaction
//  rsp       valid / stall    out         updated interior point per transaction
//  csr       write_enable     in          one register write, no read-back
//
//  Sustained rate is one grid point per cycle while rsp is not stalled; a result
//  leaves once the point that completes its neighborhood has passed the line
//  store read register and the six-stage arithmetic lane.
//  Reset is synchronous; the line store is not cleared and needs no sweep.
//  A held result on rsp stalls every stage, and req stalls with it.
`default_nettype none

module burgers_2d_explicit_stencil #(
   parameter int GRID_WIDTH = 256,
   parameter int FRAC_BITS  = 20
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [b2d_pkg::SAMPLE_W-1:0] req_u_sample,
   input  wire logic signed [b2d_pkg::SAMPLE_W-1:0] req_v_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [b2d_pkg::SAMPLE_W-1:0]      rsp_u_next,
   output logic signed [b2d_pkg::SAMPLE_W-1:0]      rsp_v_next,
   output logic                                     rsp_frame_last,
   input  wire logic                                csr_write_enable,
   input  wire logic [b2d_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [b2d_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int ADDR_W = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
   localparam logic [b2d_pkg::LEN_W-1:0] LEN_CAP =
      (GRID_WIDTH > 511) ? 9'd511 : 9'(GRID_WIDTH);
   localparam int DEPTH = b2d_pkg::LANE_DEPTH;

   logic advance;
   logic req_accept;

   // configuration registers
   logic [b2d_pkg::LEN_W-1:0]  row_length_ff;
   logic [b2d_pkg::ROWS_W-1:0] row_total_ff;
   b2d_pkg::coef_type          coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff       <= b2d_pkg::ROW_LENGTH_RST;
         row_total_ff        <= b2d_pkg::ROW_TOTAL_RST;
         coef_ff.diffusion_x <= b2d_pkg::DIFFUSION_RST;
         coef_ff.diffusion_y <= b2d_pkg::DIFFUSION_RST;
         coef_ff.advection_x <= b2d_pkg::ADVECTION_RST;
         coef_ff.advection_y <= b2d_pkg::ADVECTION_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            b2d_pkg::CSR_ROW_LENGTH:  row_length_ff       <= csr_data[8:0];
            b2d_pkg::CSR_ROW_TOTAL:   row_total_ff        <= csr_data[15:0];
            b2d_pkg::CSR_DIFFUSION_X: coef_ff.diffusion_x <= csr_data;
            b2d_pkg::CSR_DIFFUSION_Y: coef_ff.diffusion_y <= csr_data;
            b2d_pkg::CSR_ADVECTION_X: coef_ff.advection_x <= csr_data;
            b2d_pkg::CSR_ADVECTION_Y: coef_ff.advection_y <= csr_data;
            default: ;
         endcase
      end
   end

   // effective geometry, clamped to the legal range
   logic [b2d_pkg::LEN_W-1:0]  len_eff;
   logic [b2d_pkg::ROWS_W-1:0] tot_eff;

   always_comb begin
      if (row_length_ff < b2d_pkg::LEN_MIN) begin
         len_eff = b2d_pkg::LEN_MIN;
      end else if (row_length_ff > LEN_CAP) begin
         len_eff = LEN_CAP;
      end else begin
         len_eff = row_length_ff;
      end
      tot_eff = (row_total_ff < b2d_pkg::ROWS_MIN) ? b2d_pkg::ROWS_MIN : row_total_ff;
   end

   // raster position counters
   logic [b2d_pkg::LEN_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [b2d_pkg::ROWS_W-1:0] row_cnt_ff, row_cnt_in;
   logic [b2d_pkg::LEN_W:0]    col_step;
   logic [b2d_pkg::ROWS_W:0]   row_step;
   logic                       geometry_write;
   logic                       produce, frame_end;

   assign col_step = {1'b0, col_cnt_ff} + 10'd1;
   assign row_step = {1'b0, row_cnt_ff} + 17'd1;
   assign geometry_write = csr_write_enable
                        && (csr_index == b2d_pkg::CSR_ROW_LENGTH
                         || csr_index == b2d_pkg::CSR_ROW_TOTAL);

   always_comb begin
      if (col_step >= {1'b0, len_eff}) begin
         col_cnt_in = '0;
         row_cnt_in = (row_step >= {1'b0, tot_eff}) ? '0 : row_step[b2d_pkg::ROWS_W-1:0];
      end else begin
         col_cnt_in = col_step[b2d_pkg::LEN_W-1:0];
         row_cnt_in = row_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || geometry_write) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (req_accept) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // a result is due once the neighborhood of the point up-left is complete
   assign produce   = (row_cnt_ff >= 16'd2) && (col_cnt_ff >= 9'd2)
                   && (col_cnt_ff < len_eff);
   assign frame_end = (row_cnt_ff == tot_eff - 16'd1)
                   && (col_cnt_ff == len_eff - 9'd1);

   // handshake
   assign advance    = !(rsp_valid && rsp_stall);
   assign req_stall  = reset || !advance;
   assign req_accept = req_valid && !req_stall;

   // line store read stage
   logic                   s1_valid_ff, s1_produce_ff, s1_last_ff;
   b2d_pkg::point_type     s1_low_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;
   b2d_pkg::line_word_type line_rd, line_wr;
   b2d_pkg::point_type     arrival;

   assign arrival.u = req_u_sample;
   assign arrival.v = req_v_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_produce_ff <= 1'b0;
         s1_last_ff    <= 1'b0;
      end else if (advance) begin
         s1_valid_ff   <= req_accept;
         s1_produce_ff <= produce;
         s1_last_ff    <= frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_low_ff  <= arrival;
         s1_addr_ff <= ADDR_W'(col_cnt_ff);
      end
   end

   // the centre row moves up, the arriving row becomes the centre row
   logic shift_en;

   assign shift_en       = advance && s1_valid_ff;
   assign line_wr.upper  = line_rd.middle;
   assign line_wr.middle = s1_low_ff;

   b2d_line_store #(
      .DEPTH  (GRID_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (ADDR_W'(col_cnt_ff)),
      .rd_data (line_rd),
      .wr_en   (shift_en),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr)
   );

   // window column cells: near holds column c-1, far holds column c-2
   b2d_pkg::column_type column_new, column_near, column_far;

   assign column_new.top = line_rd.upper;
   assign column_new.mid = line_rd.middle;
   assign column_new.low = s1_low_ff;

   b2d_cell u_cell_near (
      .clock        (clock),
      .reset        (reset),
      .shift_en     (shift_en),
      .shift_column (column_new),
      .held_column  (column_near)
   );

   b2d_cell u_cell_far (
      .clock        (clock),
      .reset        (reset),
      .shift_en     (shift_en),
      .shift_column (column_near),
      .held_column  (column_far)
   );

   // arithmetic lanes, one per component
   b2d_pkg::sample_type u_result, v_result;

   b2d_lane #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_u (
      .clock    (clock),
      .advance  (advance),
      .centre   (column_near.mid.u),
      .north    (column_near.top.u),
      .south    (column_near.low.u),
      .west     (column_far.mid.u),
      .east     (line_rd.middle.u),
      .u_centre (column_near.mid.u),
      .v_centre (column_near.mid.v),
      .coef     (coef_ff),
      .result   (u_result)
   );

   b2d_lane #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_v (
      .clock    (clock),
      .advance  (advance),
      .centre   (column_near.mid.v),
      .north    (column_near.top.v),
      .south    (column_near.low.v),
      .west     (column_far.mid.v),
      .east     (line_rd.middle.v),
      .u_centre (column_near.mid.u),
      .v_centre (column_near.mid.v),
      .coef     (coef_ff),
      .result   (v_result)
   );

   // valid and frame-end tags alongside the lanes
   logic [DEPTH-1:0] vld_ff, last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         last_ff <= '0;
      end else if (advance) begin
         vld_ff  <= {vld_ff[DEPTH-2:0], s1_valid_ff && s1_produce_ff};
         last_ff <= {last_ff[DEPTH-2:0], s1_last_ff};
      end
   end

   // result channel
   assign rsp_valid      = vld_ff[DEPTH-1];
   assign rsp_frame_last = last_ff[DEPTH-1];
   assign rsp_u_next     = u_result;
   assign rsp_v_next     = v_result;

endmodule

`default_nettype wire

>>> hdl/b2d_checker.sv
// ---------------------------------------------------------------------------
// b2d_checker
// Port-level checks of the stencil engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module b2d_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic signed [b2d_pkg::SAMPLE_W-1:0] req_u_sample,
   input wire logic signed [b2d_pkg::SAMPLE_W-1:0] req_v_sample,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [b2d_pkg::SAMPLE_W-1:0] rsp_u_next,
   input wire logic signed [b2d_pkg::SAMPLE_W-1:0] rsp_v_next,
   input wire logic                                rsp_frame_last
);

   // a stalled result holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_u_next)
         && $stable(rsp_v_next) && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   // a stalled input transaction stays on the bus unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_u_sample)
         && $stable(req_v_sample))
      else $error("input changed while stalled");

   // no input transaction is taken during reset
   a_reset_stall: assert property (@(posedge clock)
      reset |-> req_stall)
      else $error("input not stalled during reset");

   // reset flushes the result pipeline
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a held result stops the whole pipeline, input included
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result held");

endmodule

bind burgers_2d_explicit_stencil b2d_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_u_sample   (req_u_sample),
   .req_v_sample   (req_v_sample),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_u_next     (rsp_u_next),
   .rsp_v_next     (rsp_v_next),
   .rsp_frame_last (rsp_frame_last)
);

`default_nettype wire

>>> bench/tb_burgers_2d_explicit_stencil.sv
// ---------------------------------------------------------------------------
// tb_burgers_2d_explicit_stencil
// Self-checking bench for the streaming Burgers stencil. A queue-fed driver
// sends raster grid points, a predictor with its own line stores and window
// works out each updated interior point, and a monitor compares every
// result transaction in order. Both channels idle at random, and the run
// steps through many grid shapes and coefficient sets.
// ---------------------------------------------------------------------------
module tb_burgers_2d_explicit_stencil;

   localparam int GRID          = 256;
   localparam int FRAC          = 20;
   localparam int ADV_SHIFT     = 2 * FRAC + 32;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD     = 300;
   localparam int IDLE_LIMIT    = 4000;
   localparam int TARGET_POINTS = 1625;

   // register indexes the block does not decode
   localparam logic [b2d_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [b2d_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      b2d_pkg::sample_type u_next;
      b2d_pkg::sample_type v_next;
      logic                frame_last;
   } stencil_result_type;

   logic                            clock;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_stall;
   b2d_pkg::sample_type             req_u_sample     = '0;
   b2d_pkg::sample_type             req_v_sample     = '0;
   logic                            rsp_valid;
   logic                            rsp_stall        = 1'b0;
   b2d_pkg::sample_type             rsp_u_next;
   b2d_pkg::sample_type             rsp_v_next;
   logic                            rsp_frame_last;
   logic                            csr_write_enable = 1'b0;
   logic [b2d_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [b2d_pkg::CSR_DATA_W-1:0]  csr_data         = '0;

   // predictor copy of the registers
   int                         cfg_len    = int'(b2d_pkg::ROW_LENGTH_RST);
   int                         cfg_rows   = int'(b2d_pkg::ROW_TOTAL_RST);
   logic [b2d_pkg::COEF_W-1:0] cfg_diff_x = b2d_pkg::DIFFUSION_RST;
   logic [b2d_pkg::COEF_W-1:0] cfg_diff_y = b2d_pkg::DIFFUSION_RST;
   logic [b2d_pkg::COEF_W-1:0] cfg_adv_x  = b2d_pkg::ADVECTION_RST;
   logic [b2d_pkg::COEF_W-1:0] cfg_adv_y  = b2d_pkg::ADVECTION_RST;

   // predictor copy of the line stores, window and raster position
   b2d_pkg::point_type upper_store [GRID];
   b2d_pkg::point_type middle_store [GRID];
   b2d_pkg::point_type win [6];
   int                 col_pos = 0;
   int                 row_pos = 0;

   b2d_pkg::point_type pending_points [$];
   stencil_result_type expected_points [$];

   int   items_sent     = 0;
   int   accepted_count = 0;
   int   mismatches     = 0;
   int   idle_cycles    = 0;
   int   req_gap        = 0;
   int   stall_left     = 0;
   bit   req_idle       = 1'b1;
   bit   rsp_idle       = 1'b1;
   bit   hold_trigger   = 1'b0;
   bit   hold_seen      = 1'b0;

   burgers_2d_explicit_stencil #(
      .GRID_WIDTH(GRID),
      .FRAC_BITS (FRAC)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_u_sample    (req_u_sample),
      .req_v_sample    (req_v_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_u_next      (rsp_u_next),
      .rsp_v_next      (rsp_v_next),
      .rsp_frame_last  (rsp_frame_last),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------
   // arithmetic of the stencil
   // ------------------------------------------------------------------

   // laplacian times a Q0.32 coefficient, rounded half away from zero
   function automatic longint diffusion_term(input longint lap,
                                             input logic [b2d_pkg::COEF_W-1:0] coef);
      logic [63:0]  m;
      logic [127:0] p;
      logic [63:0]  r;
      m = (lap < 0) ? 64'(-lap) : 64'(lap);
      p = {64'd0, m} * {96'd0, coef};
      r = p[95:32] + {63'd0, p[31]};
      return (lap < 0) ? -longint'(r) : longint'(r);
   endfunction

   // velocity times central difference times coefficient, same rounding
   function automatic longint advection_term(input longint a, input longint d,
                                             input logic [b2d_pkg::COEF_W-1:0] coef);
      longint       prod;
      logic [63:0]  m;
      logic [127:0] p;
      logic [127:0] r;
      prod = a * d;
      m = (prod < 0) ? 64'(-prod) : 64'(prod);
      p = {64'd0, m} * {96'd0, coef};
      r = (p >> ADV_SHIFT) + ((p >> (ADV_SHIFT - 1)) & 128'd1);
      return (prod < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   // one velocity component of the explicit update, saturated
   function automatic b2d_pkg::sample_type next_component(
      input b2d_pkg::sample_type c, n, s, w, e,
      input b2d_pkg::sample_type uc, vc);
      longint      sum;
      logic [63:0] bits;
      sum = longint'(c);
      sum += diffusion_term(longint'(e) + longint'(w) - 2 * longint'(c), cfg_diff_x);
      sum += diffusion_term(longint'(s) + longint'(n) - 2 * longint'(c), cfg_diff_y);
      sum -= advection_term(longint'(uc), longint'(e) - longint'(w), cfg_adv_x);
      sum -= advection_term(longint'(vc), longint'(s) - longint'(n), cfg_adv_y);
      if (sum > longint'(b2d_pkg::SAT_MAX)) return b2d_pkg::SAT_MAX;
      if (sum < longint'(b2d_pkg::SAT_MIN)) return b2d_pkg::SAT_MIN;
      bits = sum;
      return b2d_pkg::sample_type'(bits[b2d_pkg::SAMPLE_W-1:0]);
   endfunction

   // advance the predictor by one grid point, queue any result it completes
   function automatic void predict_point(input b2d_pkg::sample_type u_in,
                                         input b2d_pkg::sample_type v_in);
      int                 len;
      int                 tot;
      int                 col;
      b2d_pkg::point_type top;
      b2d_pkg::point_type mid;
      b2d_pkg::point_type low;
      stencil_result_type res;
      len = (cfg_len < 3) ? 3 : cfg_len;
      if (len > GRID) len = GRID;
      tot = (cfg_rows < 3) ? 3 : cfg_rows;
      col = col_pos;
      top = '0;
      mid = '0;
      low.u = u_in;
      low.v = v_in;
      if (col < GRID) begin
         top = upper_store[col];
         mid = middle_store[col];
      end
      // centre is one row up and one column left of the arriving point
      if (row_pos >= 2 && col >= 2 && col < len) begin
         res.u_next = next_component(win[2].u, win[0].u, win[4].u, win[3].u, mid.u,
                                     win[2].u, win[2].v);
         res.v_next = next_component(win[2].v, win[0].v, win[4].v, win[3].v, mid.v,
                                     win[2].u, win[2].v);
         res.frame_last = (row_pos == tot - 1 && col == len - 1);
         expected_points.push_back(res);
      end
      win[1] = win[0];
      win[0] = top;
      win[3] = win[2];
      win[2] = mid;
      win[5] = win[4];
      win[4] = low;
      if (col < GRID) begin
         upper_store[col]  = mid;
         middle_store[col] = low;
      end
      if (col + 1 >= len) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= tot) ? 0 : row_pos + 1;
      end else begin
         col_pos = col + 1;
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic b2d_pkg::sample_type rand_sample();
      logic [31:0] raw;
      int          r;
      raw = $urandom;
      r = $urandom_range(9);
      if (r < 2) begin
         case (raw[2:0])
            3'd0:    return b2d_pkg::SAT_MAX;
            3'd1:    return b2d_pkg::SAT_MIN;
            3'd2:    return '0;
            3'd3:    return '1;
            3'd4:    return 24'sd1;
            default: return b2d_pkg::SAT_MAX;
         endcase
      end
      // around plus or minus one in Q4.20
      if (r < 6) raw = $urandom_range(32'h200000) - 32'h100000;
      return b2d_pkg::sample_type'(raw[b2d_pkg::SAMPLE_W-1:0]);
   endfunction

   function automatic logic [b2d_pkg::COEF_W-1:0] random_coef();
      logic [31:0] raw;
      int          r;
      raw = $urandom;
      r = $urandom_range(99);
      if (r < 15) return '0;
      if (r < 30) return '1;
      if (r < 65) return raw >> $urandom_range(8, 2);
      return raw;
   endfunction

   function automatic void push_point(input b2d_pkg::sample_type u,
                                      input b2d_pkg::sample_type v);
      b2d_pkg::point_type p;
      p.u = u;
      p.v = v;
      pending_points.push_back(p);
      items_sent++;
   endfunction

   // register write at the next edge, mirrored into the predictor
   task automatic write_reg(input logic [b2d_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [b2d_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      case (idx)
         b2d_pkg::CSR_ROW_LENGTH: begin
            cfg_len = int'(data[b2d_pkg::LEN_W-1:0]);
            col_pos = 0;
            row_pos = 0;
         end
         b2d_pkg::CSR_ROW_TOTAL: begin
            cfg_rows = int'(data[b2d_pkg::ROWS_W-1:0]);
            col_pos = 0;
            row_pos = 0;
         end
         b2d_pkg::CSR_DIFFUSION_X: cfg_diff_x = data;
         b2d_pkg::CSR_DIFFUSION_Y: cfg_diff_y = data;
         b2d_pkg::CSR_ADVECTION_X: cfg_adv_x  = data;
         b2d_pkg::CSR_ADVECTION_Y: cfg_adv_y  = data;
         default: ;
      endcase
   endtask

   task automatic close_writes();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_coefs(input bit every);
      logic [b2d_pkg::CSR_INDEX_W-1:0] idx;
      for (idx = b2d_pkg::CSR_DIFFUSION_X; idx <= b2d_pkg::CSR_ADVECTION_Y; idx++)
         if (every || $urandom_range(1) == 1) write_reg(idx, random_coef());
   endtask

   // all points taken, all results back, then let the pipeline empty
   task automatic wait_drained();
      while (accepted_count != items_sent || expected_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // driver: one grid point per req transaction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_side
      b2d_pkg::point_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_point(req_u_sample, req_v_sample);
            accepted_count++;
         end
         // a stalled point stays on the bus unchanged
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (pending_points.size() != 0) begin
               nxt = pending_points.pop_front();
               req_u_sample <= nxt.u;
               req_v_sample <= nxt.v;
               req_valid    <= 1'b1;
               req_gap      <= req_idle ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver stall, with one long hold on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      int len;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_seen  <= 1'b0;
      end else if (hold_seen != hold_trigger) begin
         hold_seen  <= hold_trigger;
         rsp_stall  <= 1'b1;
         stall_left <= LONG_HOLD;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         len = rsp_idle ? pick_gap() : 0;
         rsp_stall  <= (len > 0);
         stall_left <= (len > 0) ? len - 1 : 0;
      end
   end

   // ------------------------------------------------------------------
   // monitor: compare each result transaction with the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      stencil_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with nothing expected: u=%h v=%h last=%b",
                        rsp_u_next, rsp_v_next, rsp_frame_last);
         end else begin
            want = expected_points.pop_front();
            if (rsp_u_next !== want.u_next || rsp_v_next !== want.v_next ||
                rsp_frame_last !== want.frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected u=%h v=%h last=%b, got u=%h v=%h last=%b",
                           want.u_next, want.v_next, want.frame_last,
                           rsp_u_next, rsp_v_next, rsp_frame_last);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      b2d_pkg::sample_type corner [5];
      int                  eff_len;
      int                  eff_rows;
      int                  len_val;
      int                  rows_val;
      int                  n;
      int                  split;
      int                  phase;
      int                  k;

      for (k = 0; k < GRID; k++) begin
         upper_store[k]  = '0;
         middle_store[k] = '0;
      end
      for (k = 0; k < 6; k++) win[k] = '0;
      corner[0] = '0;
      corner[1] = '1;
      corner[2] = 24'sd1;
      corner[3] = b2d_pkg::SAT_MAX;
      corner[4] = b2d_pkg::SAT_MIN;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // short lengths clamp to a 3x3 frame, reset coefficients, extreme checkerboard
      write_reg(b2d_pkg::CSR_ROW_LENGTH, 32'd1);
      write_reg(b2d_pkg::CSR_ROW_TOTAL, 32'd2);
      close_writes();
      for (k = 0; k < 9; k++)
         push_point(k[0] ? b2d_pkg::SAT_MAX : b2d_pkg::SAT_MIN,
                    k[0] ? b2d_pkg::SAT_MIN : b2d_pkg::SAT_MAX);

      // 4x4 frame, full-scale coefficients, undecoded indexes ignored
      wait_drained();
      write_reg(b2d_pkg::CSR_ROW_LENGTH, 32'd4);
      write_reg(b2d_pkg::CSR_ROW_TOTAL, 32'd4);
      write_reg(b2d_pkg::CSR_DIFFUSION_X, '1);
      write_reg(b2d_pkg::CSR_DIFFUSION_Y, '1);
      write_reg(b2d_pkg::CSR_ADVECTION_X, '1);
      write_reg(b2d_pkg::CSR_ADVECTION_Y, '1);
      write_reg(CSR_SPARE_LO, 32'd3);
      write_reg(CSR_SPARE_HI, '1);
      close_writes();
      for (k = 0; k < 16; k++)
         push_point(corner[k % 5], corner[(k * 3 + 1) % 5]);

      // row length past the line store and the tallest frame, left unfinished
      wait_drained();
      write_reg(b2d_pkg::CSR_ROW_LENGTH, 32'd511);
      write_reg(b2d_pkg::CSR_ROW_TOTAL, 32'd65535);
      write_coefs(1'b1);
      close_writes();
      for (k = 0; k < 640; k++) push_point(rand_sample(), rand_sample());
      eff_len  = GRID;
      eff_rows = 65535;

      // random phases: mostly whole frames of small grids
      phase = 0;
      while (items_sent < TARGET_POINTS) begin
         wait_drained();
         if (phase == 0 || $urandom_range(3) != 0) begin
            k = (phase == 0) ? 0 : $urandom_range(9);
            len_val = (k < 7) ? $urandom_range(12, 3) :
                      (k < 8) ? $urandom_range(2, 0) :
                      (k < 9) ? $urandom_range(40, 13) : $urandom_range(511, 41);
            k = (phase == 0) ? 0 : $urandom_range(9);
            rows_val = (k < 7) ? $urandom_range(8, 3) :
                       (k < 8) ? $urandom_range(2, 0) : $urandom_range(24, 9);
            write_reg(b2d_pkg::CSR_ROW_LENGTH, 32'(len_val));
            write_reg(b2d_pkg::CSR_ROW_TOTAL, 32'(rows_val));
            eff_len  = (len_val < 3) ? 3 : (len_val > GRID) ? GRID : len_val;
            eff_rows = (rows_val < 3) ? 3 : rows_val;
         end
         write_coefs(1'b0);
         if ($urandom_range(7) == 0)
            write_reg($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
         close_writes();

         req_idle = (phase != 0) && ($urandom_range(4) != 0);
         rsp_idle = (phase != 0) && ($urandom_range(4) != 0);
         n = eff_len * eff_rows * $urandom_range(3, 1);
         if ($urandom_range(3) == 0) n += $urandom_range(2 * eff_len, 1);
         if (n > 500) n = 500;
         // first phase: receiver holds off while points keep coming
         if (phase == 0) begin
            if (n < 400) n = 400;
            hold_trigger = ~hold_trigger;
         end
         // sometimes the sender stops halfway until all results are back
         split = (phase == 1 || $urandom_range(4) == 0) ? n / 2 : n;
         for (k = 0; k < split; k++) push_point(rand_sample(), rand_sample());
         if (split < n) begin
            wait_drained();
            for (k = split; k < n; k++) push_point(rand_sample(), rand_sample());
         end
         phase++;
      end

      wait_drained();
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
